@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)

`endif

`endif

@@ hw/rtl/pgb_pkg.sv @@
// types and constants of the packed glyph blitter
package pgb_pkg;

  localparam int XW         = 10;
  localparam int YW         = 8;
  localparam int ADDR_W     = 18;
  localparam int COLOR_W    = 8;
  localparam int PITCH_W    = 10;
  localparam int BPP_W      = 4;
  localparam int TABLE_AW   = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_TABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 2'd2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_TABLE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    SLOT_PIXEL = 1'b0,
    SLOT_TABLE = 1'b1
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t        kind;
    logic              visible;
    logic              byte_end;
    logic [7:0]        value;
    logic [TABLE_AW-1:0] idx;
    logic [XW-1:0]     sx;
    logic [YW-1:0]     sy;
  } slot_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } out_word_t;

endpackage

@@ hw/rtl/pgb_ram.sv @@
// generic single-port-write ram with registered read
module pgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/pgb_unpack.sv @@
// input decode, glyph position state and per-pixel byte walker
`include "assert_macros.svh"
module pgb_unpack import pgb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  input  logic [BPP_W-1:0]     bpp,
  input  logic                 space,
  output logic                 slot_valid,
  output slot_t                slot
);

  logic [7:0]  glyph_width, glyph_ht, packed_byte, table_index, table_value;
  logic [10:0] origin_x, origin_y;
  logic [7:0]  offset_x, offset_y;
  cmd_t        cmd;

  logic        busy;
  slot_kind_t  kind;
  logic [7:0]  shift;
  logic [7:0]  tidx;
  logic [2:0]  rem;

  logic [7:0]  cur_width, cur_height, column_pos, row_pos;
  logic [11:0] base_x, base_y;

  logic        accept, last_fire, bpp_ok, done;
  logic [7:0]  value;
  logic [2:0]  slots_m1;
  logic [12:0] sx_full, sy_full;
  logic        in_x, in_y;
  logic [8:0]  col_inc;

  assign glyph_width  = s_axis_tdata[7:0];
  assign glyph_ht     = s_axis_tdata[15:8];
  assign origin_x     = s_axis_tdata[26:16];
  assign origin_y     = s_axis_tdata[37:27];
  assign offset_x     = s_axis_tdata[45:38];
  assign offset_y     = s_axis_tdata[53:46];
  assign packed_byte  = s_axis_tdata[61:54];
  assign table_index  = s_axis_tdata[69:62];
  assign table_value  = s_axis_tdata[77:70];
  assign cmd          = cmd_t'(s_axis_tuser);

  assign slot_valid    = busy && space;
  assign last_fire     = slot_valid && (rem == 3'd0);
  assign s_axis_tready = !busy || last_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign bpp_ok        = bpp inside {4'd1, 4'd2, 4'd4, 4'd8};
  assign done          = (cur_width == 8'd0) || (row_pos >= cur_height);

  always_comb begin
    case (bpp)
      4'd1:    value = {7'b0, shift[7]};
      4'd2:    value = {6'b0, shift[7:6]};
      4'd4:    value = {4'b0, shift[7:4]};
      default: value = shift;
    endcase
  end

  always_comb begin
    case (bpp)
      4'd1:    slots_m1 = 3'd7;
      4'd2:    slots_m1 = 3'd3;
      4'd4:    slots_m1 = 3'd1;
      default: slots_m1 = 3'd0;
    endcase
  end

  assign sx_full = {base_x[11], base_x} + {5'b0, column_pos};
  assign sy_full = {base_y[11], base_y} + {5'b0, row_pos};
  assign in_x    = !sx_full[12] && (sx_full < 13'(SCREEN_WIDTH));
  assign in_y    = !sy_full[12] && (sy_full < 13'(SCREEN_HEIGHT));
  assign col_inc = {1'b0, column_pos} + 9'd1;

  always_comb begin
    slot.kind     = kind;
    slot.visible  = (kind == SLOT_PIXEL) && !done && (value != 8'd0) && in_x && in_y;
    slot.byte_end = (rem == 3'd0);
    slot.value    = (kind == SLOT_PIXEL) ? value : shift;
    slot.idx      = tidx;
    slot.sx       = sx_full[XW-1:0];
    slot.sy       = sy_full[YW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      cur_width  <= '0;
      cur_height <= '0;
      column_pos <= '0;
      row_pos    <= '0;
      base_x     <= '0;
      base_y     <= '0;
    end else begin
      if (slot_valid) begin
        if (kind == SLOT_PIXEL && !done) begin
          if (col_inc >= {1'b0, cur_width}) begin
            column_pos <= '0;
            row_pos    <= row_pos + 8'd1;
          end else begin
            column_pos <= col_inc[7:0];
          end
        end
        shift <= shift << bpp;
        rem   <= rem - 3'd1;
        if (rem == 3'd0) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        case (cmd)
          CMD_START: begin
            cur_width  <= glyph_width;
            cur_height <= glyph_ht;
            base_x     <= {origin_x[10], origin_x} + {{4{offset_x[7]}}, offset_x};
            base_y     <= {origin_y[10], origin_y} + {{4{offset_y[7]}}, offset_y};
            column_pos <= '0;
            row_pos    <= '0;
          end
          CMD_DATA: begin
            if (bpp_ok) begin
              busy  <= 1'b1;
              kind  <= SLOT_PIXEL;
              shift <= packed_byte;
              rem   <= slots_m1;
            end
          end
          CMD_TABLE: begin
            busy  <= 1'b1;
            kind  <= SLOT_TABLE;
            shift <= table_value;
            tidx  <= table_index;
            rem   <= 3'd0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `ASSERT_NEVER(a_row_bound, row_pos > cur_height)
  `ASSERT_CLK(a_col_bound, column_pos == 8'd0 || column_pos < cur_width)
  `ASSERT_CLK(a_job_continues, slot_valid && rem != 3'd0 |=> busy)

endmodule

@@ hw/rtl/pgb_emit.sv @@
// color lookup, address multiply, last-write hold-back and output queue
`include "assert_macros.svh"
module pgb_emit import pgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  slot_valid,
  input  slot_t                 slot,
  input  logic                  use_color_table,
  input  logic [PITCH_W-1:0]    line_pitch,
  output logic                  space,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  slot_t               r1;
  logic                r1_v;
  logic                r2_v, r2_visible, r2_byte_end;
  logic [7:0]          r2_value;
  logic [XW-1:0]       r2_sx;
  logic [ADDR_W-1:0]   r2_prod;
  logic [COLOR_W-1:0]  ram_q;

  logic                held_v, held_final;
  logic [ADDR_W-1:0]   held_addr;
  logic [COLOR_W-1:0]  held_color;

  logic [ADDR_W-1:0]   new_addr;
  logic [COLOR_W-1:0]  new_color;
  logic                push, held_take, held_clear, pop;
  out_word_t           push_word;

  out_word_t           fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;
  logic [CNT_W:0]      inflight;
  out_word_t           head;

  pgb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_color_map (
    .clk   (clk),
    .we    (r1_v && r1.kind == SLOT_TABLE),
    .waddr (r1.idx),
    .wdata (r1.value),
    .raddr (r1.value),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
    end else begin
      r1_v <= slot_valid;
      r2_v <= r1_v && (r1.kind == SLOT_PIXEL);
    end
    r1          <= slot;
    r2_visible  <= r1.visible;
    r2_byte_end <= r1.byte_end;
    r2_value    <= r1.value;
    r2_sx       <= r1.sx;
    r2_prod     <= {{(ADDR_W-YW){1'b0}}, r1.sy} * {{(ADDR_W-PITCH_W){1'b0}}, line_pitch};
  end

  assign new_addr  = r2_prod + {{(ADDR_W-XW){1'b0}}, r2_sx};
  assign new_color = use_color_table ? ram_q : r2_value;

  always_comb begin
    push       = 1'b0;
    held_take  = 1'b0;
    held_clear = 1'b0;
    push_word.addr  = held_addr;
    push_word.color = held_color;
    push_word.last  = 1'b0;
    if (held_v && held_final) begin
      push           = 1'b1;
      push_word.last = 1'b1;
      if (r2_v && r2_visible) begin
        held_take = 1'b1;
      end else begin
        held_clear = 1'b1;
      end
    end else if (held_v) begin
      if (r2_v && r2_visible) begin
        push      = 1'b1;
        held_take = 1'b1;
      end else if (r2_v && r2_byte_end) begin
        push           = 1'b1;
        push_word.last = 1'b1;
        held_clear     = 1'b1;
      end
    end else if (r2_v && r2_visible) begin
      held_take = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_v <= 1'b0;
    end else if (held_take) begin
      held_v <= 1'b1;
    end else if (held_clear) begin
      held_v <= 1'b0;
    end
    if (held_take) begin
      held_addr  <= new_addr;
      held_color <= new_color;
      held_final <= r2_byte_end;
    end
  end

  assign head          = fifo_mem[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {{(OUT_DATA_W-ADDR_W-COLOR_W){1'b0}}, head.color, head.addr};
  assign m_axis_tlast  = head.last;
  assign pop           = m_axis_tvalid && m_axis_tready;

  assign inflight = {1'b0, count} + (CNT_W+1)'(r1_v) + (CNT_W+1)'(r2_v)
                  + (CNT_W+1)'(held_v);
  assign space    = inflight < (CNT_W+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) begin
      fifo_mem[wr_ptr] <= push_word;
    end
  end

  `ASSERT_CLK(a_no_overflow, push && !pop |-> count < CNT_W'(FIFO_DEPTH))
  `ASSERT_NEVER(a_credit_bound, inflight > (CNT_W+1)'(FIFO_DEPTH))
  `ASSERT_CLK(a_final_drains, held_v && held_final |=> $past(push))

endmodule

@@ hw/rtl/packed_glyph_blitter_top.sv @@
// Packed glyph blitter: turns bit-packed font glyph bytes into pixel writes.
// A data word is walked one pixel per cycle while the output side has space;
// a byte yields 8 / bits_per_pixel pixels (8 at 1 bpp, 1 at 8 bpp), a table
// word a single slot and start and ignored words none, and a start word is
// taken in the same cycle as the last pixel of the previous byte. After the
// r1 and r2 stages a visible pixel is held until a later visible pixel or
// the end of its byte shows whether it was the byte's last write. The color
// table is a 256 x 8 ram whose registered read is used at the r2 stage; it
// is not cleared at reset and must be loaded before use. A short output
// queue decouples the downstream side; the walker stalls once the queue
// together with the stages feeding it holds eight words.
module packed_glyph_blitter_top import pgb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // glyph_width, glyph_ht, origin_x, origin_y, offset_x, offset_y,
  // packed_byte, table_index, table_value, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_address, pixel_color, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BPP_W-1:0]   bits_per_pixel;
  logic               use_color_table;
  logic [PITCH_W-1:0] line_pitch;
  logic               space;
  logic               slot_valid;
  slot_t              slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel  <= BPP_W'(1);
      use_color_table <= 1'b0;
      line_pitch      <= PITCH_W'(320);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BPP:       bits_per_pixel  <= cfg_data[BPP_W-1:0];
        REG_USE_TABLE: use_color_table <= cfg_data[0];
        REG_PITCH:     line_pitch      <= cfg_data[PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pgb_unpack #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_unpack (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .bpp           (bits_per_pixel),
    .space         (space),
    .slot_valid    (slot_valid),
    .slot          (slot)
  );

  pgb_emit u_emit (
    .clk             (clk),
    .rst             (rst),
    .slot_valid      (slot_valid),
    .slot            (slot),
    .use_color_table (use_color_table),
    .line_pitch      (line_pitch),
    .space           (space),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast)
  );

endmodule
